>>> hdl/assert_macros.svh
// Assertion helpers for the module that checks its own logic (wft_back).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CHECK_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define CHECK_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

>>> hdl/wft_pkg.sv
package wft_pkg;

  localparam int TABLE_ENTRIES = 512;
  localparam int WORD_LETTERS  = 19;
  localparam int QUEUE_DEPTH   = 2;

  localparam int ENTRY_W     = $clog2(TABLE_ENTRIES + 1);
  localparam int IDX_W       = $clog2(TABLE_ENTRIES);
  localparam int LEN_W       = $clog2(WORD_LETTERS + 1);
  localparam int LET_IDX_W   = (WORD_LETTERS > 1) ? $clog2(WORD_LETTERS) : 1;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_OUT_W = 9;
  localparam int COUNT_W     = 10;
  localparam int POS_W       = 10;
  localparam int LENGTH_OUT_W = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [POS_W-1:0]   POS_MAX   = '1;

  localparam logic [1:0] REQ_CHAR  = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_END   = 2'd2;

  typedef logic [WORD_LETTERS-1:0][7:0] letters_t;

  typedef struct packed {
    logic             clear;
    letters_t         letters;
    logic [LEN_W-1:0] length;
    logic             over;
    logic [POS_W-1:0] position;
  } job_t;

  typedef struct packed {
    logic [ENTRY_OUT_W-1:0]  entry_index;
    logic                    is_new;
    logic [COUNT_W-1:0]      word_count;
    logic [LENGTH_OUT_W-1:0] word_length;
    logic [POS_W-1:0]        token_position;
    logic                    truncated;
    logic                    table_full;
  } result_t;

endpackage

>>> hdl/word_frequency_table_top.sv
// Throughput: one character item per cycle while the job queue has room; each token
// is then handled by a back-end scan of the stored entries through the word memory read
// port, and the back end takes the next job only once the last result has been taken.
// Reset: synchronous, active high; clears the token state, positions, queue and table fill.
// The table memories are not cleared; only entries below the fill count are ever read.
module word_frequency_table_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  input  logic [1:0]  s_tuser,   // [1:0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // entry_index, is_new, word_count, word_length,
                                 // token_position, truncated, table_full, zero fill
);

  wft_pkg::job_t    push_job;
  wft_pkg::job_t    head_job;
  wft_pkg::result_t result;
  logic             push;
  logic             q_full;
  logic             q_valid;
  logic             pop;

  wft_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .req_type (s_tuser),
    .ch       (s_tdata),
    .q_full   (q_full),
    .push     (push),
    .job      (push_job)
  );

  wft_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .valid    (q_valid),
    .head     (head_job)
  );

  wft_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job_in    (head_job),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .result    (result)
  );

  assign m_tdata = {3'b000, result.table_full, result.truncated, result.token_position,
                    result.word_length, result.word_count, result.is_new,
                    result.entry_index};

endmodule

>>> hdl/wft_front.sv
module wft_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    req_type,
  input  logic [7:0]    ch,
  input  logic          q_full,
  output logic          push,
  output wft_pkg::job_t job
);

  wft_pkg::letters_t            letters;
  logic [wft_pkg::LEN_W-1:0]    count;
  logic                         in_token;
  logic                         over;
  logic [wft_pkg::POS_W-1:0]    position;
  logic                         accept;
  logic                         is_sep;
  logic                         is_letter;
  logic                         finish;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    is_sep    = ch inside {8'h20, 8'h09, 8'h0A};
    is_letter = ch inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    finish    = in_token && ((req_type == wft_pkg::REQ_END) ||
                             ((req_type == wft_pkg::REQ_CHAR) && is_sep));
    push      = accept && (finish || (req_type == wft_pkg::REQ_CLEAR));
    job.clear    = (req_type == wft_pkg::REQ_CLEAR);
    job.letters  = letters;
    job.length   = count;
    job.over     = over;
    job.position = position;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      in_token <= 1'b0;
      over     <= 1'b0;
      position <= wft_pkg::POS_W'(1);
    end else if (accept) begin
      if (req_type == wft_pkg::REQ_CLEAR) begin
        count    <= '0;
        in_token <= 1'b0;
        over     <= 1'b0;
        position <= wft_pkg::POS_W'(1);
      end else if (finish) begin
        count    <= '0;
        in_token <= 1'b0;
        over     <= 1'b0;
        if (position != wft_pkg::POS_MAX) begin
          position <= position + 1'b1;
        end
      end else if ((req_type == wft_pkg::REQ_CHAR) && !is_sep) begin
        in_token <= 1'b1;
        if (is_letter) begin
          if (count < wft_pkg::LEN_W'(wft_pkg::WORD_LETTERS)) begin
            letters[count[wft_pkg::LET_IDX_W-1:0]] <= ch | 8'h20;
            count <= count + 1'b1;
          end else begin
            over <= 1'b1;
          end
        end
      end
    end
  end

endmodule

>>> hdl/wft_queue.sv
module wft_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  wft_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output wft_pkg::job_t head
);

  wft_pkg::job_t                slots [wft_pkg::QUEUE_DEPTH];
  logic [wft_pkg::Q_PTR_W-1:0]  wr_ptr;
  logic [wft_pkg::Q_PTR_W-1:0]  rd_ptr;
  logic [wft_pkg::Q_CNT_W-1:0]  fill;

  assign full  = (fill == wft_pkg::Q_CNT_W'(wft_pkg::QUEUE_DEPTH));
  assign valid = (fill != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        slots[wr_ptr] <= push_job;
        wr_ptr <= (wr_ptr == wft_pkg::Q_PTR_W'(wft_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && valid) begin
        rd_ptr <= (rd_ptr == wft_pkg::Q_PTR_W'(wft_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + wft_pkg::Q_CNT_W'(push && !full) - wft_pkg::Q_CNT_W'(pop && valid);
    end
  end

endmodule

>>> hdl/wft_back.sv
`include "assert_macros.svh"

module wft_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  input  wft_pkg::job_t    job_in,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output wft_pkg::result_t result
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  localparam int ROW_W = wft_pkg::LEN_W + 8 * wft_pkg::WORD_LETTERS;

  logic [ROW_W-1:0]            word_mem [wft_pkg::TABLE_ENTRIES];
  logic [wft_pkg::COUNT_W-1:0] count_mem [wft_pkg::TABLE_ENTRIES];

  state_t                      state;
  wft_pkg::job_t               job;
  logic [wft_pkg::ENTRY_W-1:0] entry_count;
  logic [wft_pkg::ENTRY_W-1:0] idx;
  logic [wft_pkg::IDX_W-1:0]   cmp_idx;
  logic                        cmp_valid;
  logic [ROW_W-1:0]            row_rd;
  logic [wft_pkg::COUNT_W-1:0] count_rd;

  wft_pkg::letters_t           row_letters;
  logic [wft_pkg::LEN_W-1:0]   row_length;
  logic                        match;
  logic                        issue;
  logic                        hit;
  logic                        miss;
  logic                        room;
  logic [wft_pkg::COUNT_W-1:0] count_inc;

  always_comb begin
    row_letters = row_rd[8*wft_pkg::WORD_LETTERS-1:0];
    row_length  = row_rd[ROW_W-1 -: wft_pkg::LEN_W];
    match = (row_length == job.length);
    for (int k = 0; k < wft_pkg::WORD_LETTERS; k++) begin
      if ((wft_pkg::LEN_W'(k) < job.length) && (row_letters[k] != job.letters[k])) begin
        match = 1'b0;
      end
    end
    hit   = (state == S_SCAN) && cmp_valid && match;
    issue = (state == S_SCAN) && !hit && (idx < entry_count);
    miss  = (state == S_SCAN) && !cmp_valid && (idx >= entry_count);
    room  = (entry_count < wft_pkg::ENTRY_W'(wft_pkg::TABLE_ENTRIES));
    count_inc = (count_rd == wft_pkg::COUNT_MAX) ? count_rd : count_rd + 1'b1;
    pop = (state == S_IDLE) && job_valid && !out_valid;
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      row_rd   <= word_mem[idx[wft_pkg::IDX_W-1:0]];
      count_rd <= count_mem[idx[wft_pkg::IDX_W-1:0]];
    end
    if (miss && room) begin
      word_mem[entry_count[wft_pkg::IDX_W-1:0]]  <= {job.length, job.letters};
      count_mem[entry_count[wft_pkg::IDX_W-1:0]] <= wft_pkg::COUNT_W'(1);
    end else if (hit) begin
      count_mem[cmp_idx] <= count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      idx         <= '0;
      cmp_valid   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            if (job_in.clear) begin
              entry_count <= '0;
            end else begin
              job       <= job_in;
              idx       <= '0;
              cmp_valid <= 1'b0;
              state     <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          cmp_valid <= issue;
          if (issue) begin
            cmp_idx <= idx[wft_pkg::IDX_W-1:0];
            idx     <= idx + 1'b1;
          end
          if (hit || miss) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
            result.word_length    <= wft_pkg::LENGTH_OUT_W'(job.length);
            result.token_position <= job.position;
            result.truncated      <= job.over;
            if (hit) begin
              result.entry_index <= wft_pkg::ENTRY_OUT_W'(cmp_idx);
              result.is_new      <= 1'b0;
              result.word_count  <= count_inc;
              result.table_full  <= 1'b0;
            end else if (room) begin
              result.entry_index <= wft_pkg::ENTRY_OUT_W'(entry_count);
              result.is_new      <= 1'b1;
              result.word_count  <= wft_pkg::COUNT_W'(1);
              result.table_full  <= 1'b0;
              entry_count        <= entry_count + 1'b1;
            end else begin
              result.entry_index <= '0;
              result.is_new      <= 1'b0;
              result.word_count  <= '0;
              result.table_full  <= 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `CHECK_ALWAYS(a_count_bound, entry_count <= wft_pkg::ENTRY_W'(wft_pkg::TABLE_ENTRIES), "entry count overflow")
  `CHECK_ALWAYS(a_scan_bound, (state != S_SCAN) || (idx <= entry_count), "scan index past table")
  `CHECK_NEXT(a_result_shown, (hit || miss), out_valid, "finished token gave no result")
  `CHECK_NEXT(a_append_grows, (miss && room), (entry_count == $past(entry_count) + 1'b1), "append lost")

endmodule
